/* rtl/core/e2q_pkg.sv */
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared constants and types for the Euler angle to quaternion pipeline.
// ----------------------------------------------------------------------------
package e2q_pkg;

  localparam int ANGLE_BITS   = 17;
  localparam int QUAT_BITS    = 16;
  localparam int PHASE_BITS   = 32;
  localparam int CORDIC_STEPS = 30;

  // CORDIC datapath widths: x and y carry Q30 values, z a phase residual.
  localparam int XW  = 33;
  localparam int ZW  = 33;
  localparam int PW  = 34;          // rounded pairwise product, Q30
  localparam int PPW = 2 * XW;      // raw pairwise product, Q60
  localparam int TW  = PW + XW;     // triple product, Q60
  localparam int SW  = TW + 1;      // sum of two triple products
  localparam int QSH = 60 - (QUAT_BITS - 1);
  localparam int RW  = SW - QSH;

  localparam int NUM_STAGES = CORDIC_STEPS + 7;

  localparam logic [XW-1:0] CORDIC_GAIN = XW'(652032874);

  localparam logic [PHASE_BITS-1:0] ROT_ANGLE [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [1:0]           quad;
  } cor_t;

endpackage

/* rtl/core/euler_to_quaternion.sv */
// ----------------------------------------------------------------------------
// euler_to_quaternion
// Pipelined conversion of ZYX Euler angles to a unit quaternion.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one word of three angles (roll, pitch, yaw),
// each a two's complement code with 32768 codes per pi radians, so the full
// code range spans 4 pi. The output channel carries one word of the four
// quaternion components x, y, z, w in signed Q1.15, saturated at both ends.
// Both channels use valid/ready; a word moves when both are high.
// The word passes through 37 register stages: the phase stage, 30 CORDIC
// iteration stages, and the quadrant, multiply, round, multiply, sum and
// output stages. Throughput is one word per cycle while the receiver
// keeps out_ready_i high.
// Every stage has its own valid bit and takes a new word whenever it is
// empty or its successor moves, so bubbles collapse when the receiver
// stalls and the input keeps being accepted until every stage is full.
// Reset clears all valid bits; the data registers are not reset.
// The block holds no state between words.
// ----------------------------------------------------------------------------
module euler_to_quaternion (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [e2q_pkg::ANGLE_BITS-1:0] roll_angle_i,
  input  logic signed [e2q_pkg::ANGLE_BITS-1:0] pitch_angle_i,
  input  logic signed [e2q_pkg::ANGLE_BITS-1:0] yaw_angle_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [e2q_pkg::QUAT_BITS-1:0]  quat_x_o,
  output logic signed [e2q_pkg::QUAT_BITS-1:0]  quat_y_o,
  output logic signed [e2q_pkg::QUAT_BITS-1:0]  quat_z_o,
  output logic signed [e2q_pkg::QUAT_BITS-1:0]  quat_w_o
);

  localparam int NS = e2q_pkg::NUM_STAGES;
  localparam int CS = e2q_pkg::CORDIC_STEPS;
  localparam int XW = e2q_pkg::XW;
  localparam int ZW = e2q_pkg::ZW;
  localparam int PW = e2q_pkg::PW;
  localparam int PPW = e2q_pkg::PPW;
  localparam int TW = e2q_pkg::TW;
  localparam int SW = e2q_pkg::SW;
  localparam int RW = e2q_pkg::RW;
  localparam int QB = e2q_pkg::QUAT_BITS;
  localparam int AB = e2q_pkg::ANGLE_BITS;
  localparam int PB = e2q_pkg::PHASE_BITS;

  // Stage indexes.
  localparam int S_FIX = CS + 1;
  localparam int S_PP  = CS + 2;
  localparam int S_RND = CS + 3;
  localparam int S_TRI = CS + 4;
  localparam int S_SUM = CS + 5;
  localparam int S_OUT = CS + 6;

  // Valid bits and the per-stage ready chain.
  logic [NS-1:0] vld_q;
  logic [NS:0]   rdy;
  logic [NS-1:0] vld_in;

  assign rdy[NS] = out_ready_i;
  assign vld_in[0] = in_valid_i;

  for (genvar k = 0; k < NS; k++) begin : g_ctl
    assign rdy[k] = !vld_q[k] || rdy[k+1];
    if (k > 0) begin : g_vin
      assign vld_in[k] = vld_q[k-1];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_q[k] <= vld_in[k];
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NS-1];

  // --------------------------------------------------------------------------
  // Stage 0: half-angle phase, quadrant split and CORDIC start vector.
  // --------------------------------------------------------------------------
  e2q_pkg::cor_t cor_q [CS+1][3];
  e2q_pkg::cor_t cor_d0 [3];
  logic [AB-1:0] ang [3];

  assign ang[0] = roll_angle_i;
  assign ang[1] = pitch_angle_i;
  assign ang[2] = yaw_angle_i;

  for (genvar a = 0; a < 3; a++) begin : g_ph
    logic [PB-1:0] phase;
    logic [PB-1:0] bias;
    logic [PB-1:0] rem;
    logic [1:0]    quad;
    always_comb begin
      phase = {ang[a], {(PB-AB){1'b0}}};
      bias  = phase + PB'(32'h2000_0000);
      quad  = bias[PB-1 -: 2];
      rem   = phase - {quad, {(PB-2){1'b0}}};
      cor_d0[a].x    = $signed(e2q_pkg::CORDIC_GAIN);
      cor_d0[a].y    = '0;
      cor_d0[a].z    = $signed({rem[PB-1], rem});
      cor_d0[a].quad = quad;
    end
    always_ff @(posedge clk_i) begin
      if (rdy[0] && vld_in[0]) begin
        cor_q[0][a] <= cor_d0[a];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stages 1..CS: one CORDIC micro-rotation per stage.
  // --------------------------------------------------------------------------
  for (genvar j = 1; j <= CS; j++) begin : g_cor
    for (genvar a = 0; a < 3; a++) begin : g_ax
      e2q_pkg::cor_t cur;
      e2q_pkg::cor_t nxt;
      logic signed [XW-1:0] dx;
      logic signed [XW-1:0] dy;
      logic signed [ZW-1:0] da;
      always_comb begin
        cur = cor_q[j-1][a];
        dx  = cur.y >>> (j - 1);
        dy  = cur.x >>> (j - 1);
        da  = $signed({1'b0, e2q_pkg::ROT_ANGLE[j-1]});
        nxt.quad = cur.quad;
        if (!cur.z[ZW-1]) begin
          nxt.x = cur.x - dx;
          nxt.y = cur.y + dy;
          nxt.z = cur.z - da;
        end else begin
          nxt.x = cur.x + dx;
          nxt.y = cur.y - dy;
          nxt.z = cur.z + da;
        end
      end
      always_ff @(posedge clk_i) begin
        if (rdy[j] && vld_in[j]) begin
          cor_q[j][a] <= nxt;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Quadrant fix-up: exact rotation by a multiple of a quarter turn.
  // --------------------------------------------------------------------------
  logic signed [XW-1:0] cos_q [3];
  logic signed [XW-1:0] sin_q [3];

  for (genvar a = 0; a < 3; a++) begin : g_fix
    logic signed [XW-1:0] c_d;
    logic signed [XW-1:0] s_d;
    always_comb begin
      unique case (cor_q[CS][a].quad)
        2'd0: begin c_d = cor_q[CS][a].x;  s_d = cor_q[CS][a].y;  end
        2'd1: begin c_d = -cor_q[CS][a].y; s_d = cor_q[CS][a].x;  end
        2'd2: begin c_d = -cor_q[CS][a].x; s_d = -cor_q[CS][a].y; end
        default: begin c_d = cor_q[CS][a].y; s_d = -cor_q[CS][a].x; end
      endcase
    end
    always_ff @(posedge clk_i) begin
      if (rdy[S_FIX] && vld_in[S_FIX]) begin
        cos_q[a] <= c_d;
        sin_q[a] <= s_d;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Roll/pitch pairwise products (Q60), then round to Q30.
  // Order: crcp, srsp, srcp, crsp.
  // --------------------------------------------------------------------------
  logic signed [PPW-1:0] pp_q  [4];
  logic signed [PPW-1:0] pp_d  [4];
  logic signed [XW-1:0]  cy_pp_q, sy_pp_q;

  assign pp_d[0] = cos_q[0] * cos_q[1];
  assign pp_d[1] = sin_q[0] * sin_q[1];
  assign pp_d[2] = sin_q[0] * cos_q[1];
  assign pp_d[3] = cos_q[0] * sin_q[1];

  always_ff @(posedge clk_i) begin
    if (rdy[S_PP] && vld_in[S_PP]) begin
      pp_q    <= pp_d;
      cy_pp_q <= cos_q[2];
      sy_pp_q <= sin_q[2];
    end
  end

  logic signed [PW-1:0] pr_q [4];
  logic signed [XW-1:0] cy_pr_q, sy_pr_q;

  for (genvar p = 0; p < 4; p++) begin : g_rnd
    logic [PPW-1:0] biased;
    assign biased = pp_q[p] + (PPW'(1) << 29);
    always_ff @(posedge clk_i) begin
      if (rdy[S_RND] && vld_in[S_RND]) begin
        pr_q[p] <= $signed(biased[30 +: PW]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[S_RND] && vld_in[S_RND]) begin
      cy_pr_q <= cy_pp_q;
      sy_pr_q <= sy_pp_q;
    end
  end

  // --------------------------------------------------------------------------
  // Triple products with the yaw terms (Q60).
  // --------------------------------------------------------------------------
  logic signed [TW-1:0] tri_q [8];
  logic signed [TW-1:0] tri_d [8];

  assign tri_d[0] = pr_q[2] * cy_pr_q;  // srcp cy
  assign tri_d[1] = pr_q[3] * sy_pr_q;  // crsp sy
  assign tri_d[2] = pr_q[3] * cy_pr_q;  // crsp cy
  assign tri_d[3] = pr_q[2] * sy_pr_q;  // srcp sy
  assign tri_d[4] = pr_q[0] * sy_pr_q;  // crcp sy
  assign tri_d[5] = pr_q[1] * cy_pr_q;  // srsp cy
  assign tri_d[6] = pr_q[0] * cy_pr_q;  // crcp cy
  assign tri_d[7] = pr_q[1] * sy_pr_q;  // srsp sy

  always_ff @(posedge clk_i) begin
    if (rdy[S_TRI] && vld_in[S_TRI]) begin
      tri_q <= tri_d;
    end
  end

  // --------------------------------------------------------------------------
  // Component sums, then round and saturate to Q1.(QB-1).
  // --------------------------------------------------------------------------
  logic signed [SW-1:0] sum_q [4];
  logic signed [SW-1:0] sum_d [4];

  assign sum_d[0] = SW'(tri_q[0]) - SW'(tri_q[1]);
  assign sum_d[1] = SW'(tri_q[2]) + SW'(tri_q[3]);
  assign sum_d[2] = SW'(tri_q[4]) - SW'(tri_q[5]);
  assign sum_d[3] = SW'(tri_q[6]) + SW'(tri_q[7]);

  always_ff @(posedge clk_i) begin
    if (rdy[S_SUM] && vld_in[S_SUM]) begin
      sum_q <= sum_d;
    end
  end

  localparam logic signed [RW-1:0] QMAX = RW'((64'd1 << (QB - 1)) - 64'd1);
  localparam logic signed [RW-1:0] QMIN = ~QMAX;

  logic signed [QB-1:0] quat_q [4];

  for (genvar q = 0; q < 4; q++) begin : g_out
    logic [SW-1:0]        biased;
    logic signed [RW-1:0] r;
    logic signed [QB-1:0] sat;
    always_comb begin
      biased = sum_q[q] + (SW'(1) << (e2q_pkg::QSH - 1));
      r      = $signed(biased[SW-1 -: RW]);
      if (r > QMAX) begin
        sat = QMAX[QB-1:0];
      end else if (r < QMIN) begin
        sat = QMIN[QB-1:0];
      end else begin
        sat = r[QB-1:0];
      end
    end
    always_ff @(posedge clk_i) begin
      if (rdy[S_OUT] && vld_in[S_OUT]) begin
        quat_q[q] <= sat;
      end
    end
  end

  assign quat_x_o = quat_q[0];
  assign quat_y_o = quat_q[1];
  assign quat_z_o = quat_q[2];
  assign quat_w_o = quat_q[3];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_accept_fills_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted word did not enter the first stage");

  a_last_feeds_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NS-2] && rdy[NS-1] |=> out_valid_o)
    else $error("word lost between the last two stages");

  a_full_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($countones(vld_q) == NS) && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while the pipeline is full and stalled");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euler angle to quaternion testbench
// Drives angle triples through the valid/ready input, predicts each
// quaternion with a bit-exact CORDIC model unless a directed row gives it,
// and compares each output word field by field under random idles and stalls.
// ----------------------------------------------------------------------------
module testbench;

  localparam int LATENCY = 37;
  localparam int RANDOM_WORDS = 1880;

  typedef logic signed [e2q_pkg::ANGLE_BITS-1:0] angle_t;
  typedef logic signed [e2q_pkg::QUAT_BITS-1:0] comp_t;

  typedef struct {
    comp_t x;
    comp_t y;
    comp_t z;
    comp_t w;
  } quat_t;

  // One row of the directed table. When known is set, the expected
  // quaternion is written out by hand; otherwise the predictor supplies it.
  typedef struct {
    angle_t roll;
    angle_t pitch;
    angle_t yaw;
    bit     known;
    quat_t  q;
  } vector_t;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  in_valid_i = 1'b0;
  logic  in_ready_o;
  angle_t roll_angle_i = '0;
  angle_t pitch_angle_i = '0;
  angle_t yaw_angle_i = '0;
  logic  out_valid_o;
  logic  out_ready_i = 1'b0;
  comp_t quat_x_o, quat_y_o, quat_z_o, quat_w_o;

  quat_t expected_quats[$];
  int    n_errors = 0;
  int    n_words_in = 0;
  int    n_words_out = 0;
  int    send_idle_pct = 29;
  int    recv_idle_pct = 60;
  bit    recv_hold = 1'b0;

  always #6 clk_i = ~clk_i;

  euler_to_quaternion DUT (.*);

  // Floor shift for signed 64-bit values; >>> already floors.
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  // Sine and cosine in Q30 of a phase in 2^-32 turn units.
  task automatic half_sincos(input logic [31:0] phase, output longint c,
                             output longint s);
    logic [1:0]  quad;
    logic [31:0] rem;
    longint      x, y, z, dx, dy;
    quad = 2'((phase + 32'h2000_0000) >> 30);
    rem = phase - {quad, 30'd0};
    z = longint'($signed(rem));
    x = 652032874;
    y = 0;
    for (int i = 0; i < e2q_pkg::CORDIC_STEPS; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(e2q_pkg::ROT_ANGLE[i]);
      end else begin
        x += dx; y -= dy; z += longint'(e2q_pkg::ROT_ANGLE[i]);
      end
    end
    case (quad)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  function automatic longint round_q30(longint a, longint b);
    return floor_shift(a * b + (longint'(1) << 29), 30);
  endfunction

  // Q60 sum to a saturated Q1.15 component.
  function automatic comp_t saturate_q60(longint v);
    longint r;
    r = floor_shift(v + (longint'(1) << (e2q_pkg::QSH - 1)), e2q_pkg::QSH);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return comp_t'(r);
  endfunction

  task automatic euler_to_quat(input angle_t roll, input angle_t pitch,
                               input angle_t yaw, output quat_t q);
    longint cr, sr, cp, sp, cy, sy, crcp, srsp, srcp, crsp;
    // A 17-bit code spans a full turn of the half angle.
    half_sincos({roll, 15'd0}, cr, sr);
    half_sincos({pitch, 15'd0}, cp, sp);
    half_sincos({yaw, 15'd0}, cy, sy);
    crcp = round_q30(cr, cp);
    srsp = round_q30(sr, sp);
    srcp = round_q30(sr, cp);
    crsp = round_q30(cr, sp);
    q.x = saturate_q60(srcp * cy - crsp * sy);
    q.y = saturate_q60(crsp * cy + srcp * sy);
    q.z = saturate_q60(crcp * sy - srsp * cy);
    q.w = saturate_q60(crcp * cy + srsp * sy);
  endtask

  // Offer one word and hold it until the block takes it. Valid drops only
  // when the sender decides to idle, so back-to-back words keep it high.
  task automatic send_word(input angle_t roll, input angle_t pitch, input angle_t yaw,
                           input bit known, input quat_t typed);
    quat_t q;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    euler_to_quat(roll, pitch, yaw, q);
    if (known) q = typed;
    in_valid_i <= 1'b1;
    roll_angle_i <= roll;
    pitch_angle_i <= pitch;
    yaw_angle_i <= yaw;
    do @(posedge clk_i); while (!in_ready_o);
    expected_quats.push_back(q);
    n_words_in++;
  endtask

  function automatic angle_t rand_angle();
    case ($urandom_range(5))
      0: return angle_t'($urandom_range(3) == 0 ? 17'h10000 : 17'h0ffff);
      1: return angle_t'({$urandom_range(7), 14'd0});  // multiples of pi/2
      2: return angle_t'($urandom_range(64) - 32);
      default: return angle_t'($urandom);
    endcase
  endfunction

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(posedge clk_i) begin
    out_ready_i <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // Check each accepted output word against the oldest prediction.
  always @(posedge clk_i) begin
    quat_t q;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_words_out++;
      if (expected_quats.size() == 0) begin
        $error("output word with nothing expected");
        n_errors++;
      end else begin
        q = expected_quats.pop_front();
        if (quat_x_o !== q.x) begin
          $error("quat_x expected %0d actual %0d", q.x, quat_x_o); n_errors++;
        end
        if (quat_y_o !== q.y) begin
          $error("quat_y expected %0d actual %0d", q.y, quat_y_o); n_errors++;
        end
        if (quat_z_o !== q.z) begin
          $error("quat_z expected %0d actual %0d", q.z, quat_z_o); n_errors++;
        end
        if (quat_w_o !== q.w) begin
          $error("quat_w expected %0d actual %0d", q.w, quat_w_o); n_errors++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("testbench: errors");
    $finish;
  end

  initial begin
    vector_t table_rows[$];
    quat_t   none;
    int      drain;
    none = '{0, 0, 0, 0};
    // Zero angles give the identity; a full 2 pi roll gives -1 in w.
    // The wrap-around codes at both ends and the rest are predicted.
    table_rows = '{
      '{angle_t'(0), angle_t'(0), angle_t'(0), 1, '{0, 0, 0, 32767}},
      '{angle_t'(-65536), angle_t'(0), angle_t'(0), 1, '{0, 0, 0, -32768}},
      '{angle_t'(65535), angle_t'(0), angle_t'(0), 0, none},
      '{angle_t'(0), angle_t'(-65536), angle_t'(0), 0, none},
      '{angle_t'(0), angle_t'(65535), angle_t'(0), 0, none},
      '{angle_t'(0), angle_t'(0), angle_t'(-65536), 0, none},
      '{angle_t'(0), angle_t'(0), angle_t'(65535), 0, none},
      '{angle_t'(32768), angle_t'(0), angle_t'(0), 0, none},
      '{angle_t'(0), angle_t'(32768), angle_t'(0), 0, none},
      '{angle_t'(0), angle_t'(0), angle_t'(32768), 0, none},
      '{angle_t'(16384), angle_t'(16384), angle_t'(16384), 0, none},
      '{angle_t'(-16384), angle_t'(-16384), angle_t'(-16384), 0, none},
      '{angle_t'(1), angle_t'(-1), angle_t'(1), 0, none},
      '{angle_t'(65535), angle_t'(65535), angle_t'(65535), 0, none},
      '{angle_t'(-65536), angle_t'(-65536), angle_t'(-65536), 0, none},
      '{angle_t'(21845), angle_t'(-43690), angle_t'(10922), 0, none},
      '{angle_t'(-32768), angle_t'(32767), angle_t'(-16385), 0, none},
      '{angle_t'(8192), angle_t'(24576), angle_t'(-8192), 0, none}
    };
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (table_rows[i])
      send_word(table_rows[i].roll, table_rows[i].pitch, table_rows[i].yaw,
                table_rows[i].known, table_rows[i].q);

    // Long receiver hold-off while the sender keeps offering words.
    fork
      begin
        recv_hold = 1'b1;
        repeat (200) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      begin
        send_idle_pct = 0;
        repeat (60) send_word(rand_angle(), rand_angle(), rand_angle(), 0, none);
      end
    join

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 60 : 0;
      recv_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 29 : 0;
      repeat ((RANDOM_WORDS - 60) / 3)
        send_word(rand_angle(), rand_angle(), rand_angle(), 0, none);
    end
    in_valid_i <= 1'b0;

    recv_idle_pct = 0;
    drain = 0;
    while (expected_quats.size() != 0 && drain < 100000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (2 * LATENCY) @(posedge clk_i);
    $display("Sent %0d angle words and checked %0d quaternions, including extremes,",
             n_words_in, n_words_out);
    $display("wrap-around codes and a long output stall.");
    if (n_errors == 0 && expected_quats.size() == 0) begin
      $display("testbench: clean");
    end else begin
      if (expected_quats.size() != 0)
        $error("%0d quaternions never arrived", expected_quats.size());
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
